// ----- hdl/mlfs_pkg.sv -----
// Shared types and constants for the multilevel feedback scheduler.
// Used by mlfs_ring_store and multilevel_feedback_scheduler; no dependencies.
package mlfs_pkg;

   localparam int QUEUE_DEPTH   = 8;
   localparam int JOB_ID_BITS   = 6;
   localparam int NUM_LEVELS    = 3;
   localparam int LEVEL_BITS    = 2;
   localparam int RUN_BITS      = 4;
   localparam int LIMIT_BITS    = 4;
   localparam int SLOT_BITS     = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS      = $clog2(QUEUE_DEPTH + 1);
   localparam int MEM_DEPTH     = 1 << (LEVEL_BITS + SLOT_BITS);
   localparam int REQ_DATA_BITS = ((JOB_ID_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS = ((JOB_ID_BITS + LEVEL_BITS + 7) / 8) * 8;

   typedef logic [LEVEL_BITS-1:0] level_type;

   localparam level_type LVL_HIGH   = 2'd0;
   localparam level_type LVL_MEDIUM = 2'd1;
   localparam level_type LVL_LOW    = 2'd2;

   typedef enum logic [1:0] {
      CMD_ADMIT    = 2'd0,
      CMD_DISPATCH = 2'd1,
      CMD_EXPIRE   = 2'd2,
      CMD_DONE     = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      STS_DISPATCHED = 3'd0,
      STS_EMPTY      = 3'd1,
      STS_REQUEUED   = 3'd2,
      STS_RETIRED    = 3'd3,
      STS_ADMITTED   = 3'd4,
      STS_FULL       = 3'd5,
      STS_NO_JOB     = 3'd6,
      STS_BUSY       = 3'd7
   } sts_type;

   typedef enum logic {
      FSM_IDLE = 1'b0,
      FSM_POP  = 1'b1
   } fsm_type;

   localparam int CSR_INDEX_BITS = 1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HIGH_LIMIT   = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MEDIUM_LIMIT = 1'd1;

   typedef struct packed {
      logic [JOB_ID_BITS-1:0] id;
      logic [RUN_BITS-1:0]    hruns;
      logic [RUN_BITS-1:0]    mruns;
      level_type              level;
   } entry_type;

   typedef struct packed {
      logic      valid;
      level_type level;
      entry_type entry;
   } push_req_type;

   typedef struct packed {
      logic      valid;
      level_type level;
   } pop_req_type;

   typedef struct packed {
      logic [NUM_LEVELS-1:0] nonempty;
      logic [NUM_LEVELS-1:0] full;
   } ring_status_type;

endpackage

// ----- hdl/multilevel_feedback_scheduler.sv -----
// Top level of the three-level feedback queue scheduler.
// Depends on mlfs_pkg and mlfs_ring_store.
//
// Usage: each item on the req_ channel is one command (admit, dispatch,
// quantum expired, done) in req_tuser with a job id in req_tdata. Every
// command returns exactly one item on the rsp_ channel: a status in
// rsp_tuser and the affected job and its level in rsp_tdata.
// Waiting jobs sit in three FIFO rings held in one synchronous memory; the
// running job is held in a register. The user must write the two run
// limits via the csr_ port only while the block is idle (not enforced).
// Admit, expire, done and a dispatch answered busy or empty give their
// result in the cycle after acceptance, so they sustain one item a cycle
// while rsp_tready holds. A dispatch that pops a ring takes the registered
// ring memory output in the POP state; no new item is taken in that state.
// A result waits in the output register until rsp_tready; a new item is
// accepted only when that register is empty or is emptied in the same cycle,
// so a stalled receiver holds off the request side.
// Reset empties all rings, clears the running job and loads the limits
// with 2 (high) and 4 (medium); no clearing pass is needed.
module multilevel_feedback_scheduler import mlfs_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [REQ_DATA_BITS-1:0]  req_tdata,  // job_id, zero padded
   input  logic [1:0]                req_tuser,  // command
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_DATA_BITS-1:0]  rsp_tdata,  // out_job, out_level, zero padded
   output logic [2:0]                rsp_tuser,  // status
   input  logic                      csr_wen,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [LIMIT_BITS-1:0]     csr_wdata
);

   fsm_type                state_ff, state_in;
   entry_type              running_ff, running_in;
   logic                   run_valid_ff, run_valid_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   sts_type                rsp_status_ff, rsp_status_in;
   logic [JOB_ID_BITS-1:0] rsp_job_ff, rsp_job_in;
   level_type              rsp_level_ff, rsp_level_in;
   logic [LIMIT_BITS-1:0]  high_limit_ff, medium_limit_ff;

   push_req_type           push_req;
   pop_req_type            pop_req;
   ring_status_type        ring_status;
   entry_type              pop_entry;

   cmd_type                cmd;
   logic [JOB_ID_BITS-1:0] req_job;
   logic                   req_accept;
   entry_type              admit_entry;
   entry_type              requeue_entry;
   level_type              pop_level;

   mlfs_ring_store u_ring_store (
      .clock       (clock),
      .reset       (reset),
      .push_req    (push_req),
      .pop_req     (pop_req),
      .ring_status (ring_status),
      .pop_entry   (pop_entry)
   );

   assign cmd        = cmd_type'(req_tuser);
   assign req_job    = req_tdata[JOB_ID_BITS-1:0];
   assign req_tready = (state_ff == FSM_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      admit_entry.id    = req_job;
      admit_entry.hruns = RUN_BITS'(1);
      admit_entry.mruns = '0;
      admit_entry.level = LVL_HIGH;

      requeue_entry = running_ff;
      priority if (running_ff.hruns < high_limit_ff) begin
         requeue_entry.hruns = running_ff.hruns + 1'b1;
         requeue_entry.level = LVL_HIGH;
      end else if (running_ff.mruns < medium_limit_ff) begin
         requeue_entry.mruns = running_ff.mruns + 1'b1;
         requeue_entry.level = LVL_MEDIUM;
      end else begin
         requeue_entry.level = LVL_LOW;
      end

      priority if (ring_status.nonempty[0]) begin
         pop_level = LVL_HIGH;
      end else if (ring_status.nonempty[1]) begin
         pop_level = LVL_MEDIUM;
      end else begin
         pop_level = LVL_LOW;
      end
   end

   always_comb begin
      state_in      = state_ff;
      running_in    = running_ff;
      run_valid_in  = run_valid_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_job_in    = rsp_job_ff;
      rsp_level_in  = rsp_level_ff;
      push_req      = '0;
      pop_req       = '0;

      unique case (state_ff)
         FSM_IDLE: begin
            if (req_accept) begin
               rsp_valid_in = 1'b1;
               unique case (cmd)
                  CMD_ADMIT: begin
                     rsp_job_in   = req_job;
                     rsp_level_in = LVL_HIGH;
                     if (ring_status.full[0]) begin
                        rsp_status_in = STS_FULL;
                     end else begin
                        rsp_status_in  = STS_ADMITTED;
                        push_req.valid = 1'b1;
                        push_req.level = LVL_HIGH;
                        push_req.entry = admit_entry;
                     end
                  end
                  CMD_DISPATCH: begin
                     if (run_valid_ff) begin
                        rsp_status_in = STS_BUSY;
                        rsp_job_in    = running_ff.id;
                        rsp_level_in  = running_ff.level;
                     end else if (ring_status.nonempty == '0) begin
                        rsp_status_in = STS_EMPTY;
                        rsp_job_in    = '0;
                        rsp_level_in  = LVL_HIGH;
                     end else begin
                        rsp_valid_in  = 1'b0;
                        pop_req.valid = 1'b1;
                        pop_req.level = pop_level;
                        state_in      = FSM_POP;
                     end
                  end
                  CMD_EXPIRE: begin
                     if (!run_valid_ff) begin
                        rsp_status_in = STS_NO_JOB;
                        rsp_job_in    = '0;
                        rsp_level_in  = LVL_HIGH;
                     end else begin
                        run_valid_in = 1'b0;
                        running_in   = '0;
                        rsp_job_in   = requeue_entry.id;
                        rsp_level_in = requeue_entry.level;
                        if (ring_status.full[requeue_entry.level]) begin
                           rsp_status_in = STS_FULL;
                        end else begin
                           rsp_status_in  = STS_REQUEUED;
                           push_req.valid = 1'b1;
                           push_req.level = requeue_entry.level;
                           push_req.entry = requeue_entry;
                        end
                     end
                  end
                  CMD_DONE: begin
                     if (!run_valid_ff) begin
                        rsp_status_in = STS_NO_JOB;
                        rsp_job_in    = '0;
                        rsp_level_in  = LVL_HIGH;
                     end else begin
                        rsp_status_in = STS_RETIRED;
                        rsp_job_in    = running_ff.id;
                        rsp_level_in  = running_ff.level;
                        run_valid_in  = 1'b0;
                        running_in    = '0;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b0;
                  end
               endcase
            end
         end
         FSM_POP: begin
            running_in    = pop_entry;
            run_valid_in  = 1'b1;
            rsp_valid_in  = 1'b1;
            rsp_status_in = STS_DISPATCHED;
            rsp_job_in    = pop_entry.id;
            rsp_level_in  = pop_entry.level;
            state_in      = FSM_IDLE;
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= FSM_IDLE;
         running_ff      <= '0;
         run_valid_ff    <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         high_limit_ff   <= LIMIT_BITS'(2);
         medium_limit_ff <= LIMIT_BITS'(4);
      end else begin
         state_ff     <= state_in;
         running_ff   <= running_in;
         run_valid_ff <= run_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wen && (csr_index == CSR_HIGH_LIMIT)) begin
            high_limit_ff <= csr_wdata;
         end
         if (csr_wen && (csr_index == CSR_MEDIUM_LIMIT)) begin
            medium_limit_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_job_ff    <= rsp_job_in;
      rsp_level_ff  <= rsp_level_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = RSP_DATA_BITS'({rsp_level_ff, rsp_job_ff});

`ifndef SYNTHESIS
   a_pop_output_free : assert property (@(posedge clock) disable iff (reset)
      (state_ff == FSM_POP) |-> (!rsp_valid_ff && !req_tready))
      else $error("Ring read pending while the output register is occupied.");

   a_pop_loads_job : assert property (@(posedge clock) disable iff (reset)
      (state_ff == FSM_POP) |=> (run_valid_ff && rsp_valid_ff
                                 && (rsp_status_ff == STS_DISPATCHED)))
      else $error("Ring read did not load the running job.");

   a_pop_needs_idle_cpu : assert property (@(posedge clock) disable iff (reset)
      pop_req.valid |-> (!run_valid_ff && (state_ff == FSM_IDLE)))
      else $error("Ring popped while a job is running.");
`endif

endmodule

// ----- hdl/mlfs_ring_store.sv -----
// Three FIFO rings of scheduler entries in one synchronous memory, with
// per-level head and fill count registers. Depends on mlfs_pkg.
module mlfs_ring_store import mlfs_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  push_req_type    push_req,
   input  pop_req_type     pop_req,
   output ring_status_type ring_status,
   output entry_type       pop_entry
);

   localparam int SUM_BITS = CNT_BITS + 1;

   entry_type ring_mem [MEM_DEPTH];

   logic [SLOT_BITS-1:0] head_ff [NUM_LEVELS];
   logic [SLOT_BITS-1:0] head_in [NUM_LEVELS];
   logic [CNT_BITS-1:0]  count_ff [NUM_LEVELS];
   logic [CNT_BITS-1:0]  count_in [NUM_LEVELS];
   logic [SLOT_BITS-1:0] tail [NUM_LEVELS];
   logic [SUM_BITS-1:0]  tail_sum [NUM_LEVELS];
   entry_type            pop_entry_ff;

   logic [SLOT_BITS-1:0] push_slot;
   logic [SLOT_BITS-1:0] pop_slot;

   always_comb begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
         tail_sum[i] = SUM_BITS'(head_ff[i]) + SUM_BITS'(count_ff[i]);
         if (tail_sum[i] >= SUM_BITS'(QUEUE_DEPTH)) begin
            tail[i] = SLOT_BITS'(tail_sum[i] - SUM_BITS'(QUEUE_DEPTH));
         end else begin
            tail[i] = SLOT_BITS'(tail_sum[i]);
         end
         ring_status.nonempty[i] = (count_ff[i] != '0);
         ring_status.full[i]     = (count_ff[i] >= CNT_BITS'(QUEUE_DEPTH));
         head_in[i]  = head_ff[i];
         count_in[i] = count_ff[i];
         if (push_req.valid && (push_req.level == LEVEL_BITS'(i))) begin
            count_in[i] = count_ff[i] + 1'b1;
         end
         if (pop_req.valid && (pop_req.level == LEVEL_BITS'(i))) begin
            count_in[i] = count_ff[i] - 1'b1;
            if (head_ff[i] == SLOT_BITS'(QUEUE_DEPTH - 1)) begin
               head_in[i] = '0;
            end else begin
               head_in[i] = head_ff[i] + 1'b1;
            end
         end
      end
   end

   always_comb begin
      push_slot = '0;
      pop_slot  = '0;
      for (int i = 0; i < NUM_LEVELS; i++) begin
         if (push_req.level == LEVEL_BITS'(i)) begin
            push_slot = tail[i];
         end
         if (pop_req.level == LEVEL_BITS'(i)) begin
            pop_slot = head_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_LEVELS; i++) begin
            head_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
      end else begin
         for (int i = 0; i < NUM_LEVELS; i++) begin
            head_ff[i]  <= head_in[i];
            count_ff[i] <= count_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push_req.valid) begin
         ring_mem[{push_req.level, push_slot}] <= push_req.entry;
      end
   end

   always_ff @(posedge clock) begin
      if (pop_req.valid) begin
         pop_entry_ff <= ring_mem[{pop_req.level, pop_slot}];
      end
   end

   assign pop_entry = pop_entry_ff;

`ifndef SYNTHESIS
   a_push_not_full : assert property (@(posedge clock) disable iff (reset)
      push_req.valid |-> !ring_status.full[push_req.level])
      else $error("Push issued to a full ring.");

   a_pop_not_empty : assert property (@(posedge clock) disable iff (reset)
      pop_req.valid |-> ring_status.nonempty[pop_req.level])
      else $error("Pop issued from an empty ring.");

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      (count_ff[0] <= CNT_BITS'(QUEUE_DEPTH)) && (count_ff[1] <= CNT_BITS'(QUEUE_DEPTH))
      && (count_ff[2] <= CNT_BITS'(QUEUE_DEPTH)))
      else $error("Ring fill count exceeds the ring depth.");
`endif

endmodule
